/* design/smtpclp_pkg.sv */
package smtpclp_pkg;

  // Longest line accepted, in bytes
  localparam int MAX_LINE_DEFAULT = 512;

  // Verdict status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_UNKNOWN  = 3'd1;
  localparam logic [2:0] ST_BAD_VERB = 3'd2;
  localparam logic [2:0] ST_BARE_CR  = 3'd3;
  localparam logic [2:0] ST_TOO_LONG = 3'd4;

  // Delimiter bytes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Known verbs, upper case, first letter in the top byte; index is the command code
  localparam int NUM_VERBS = 11;
  localparam logic [31:0] VERB_TABLE [NUM_VERBS] = '{
    32'h48454C4F,  // HELO
    32'h45484C4F,  // EHLO
    32'h4D41494C,  // MAIL
    32'h52435054,  // RCPT
    32'h44415441,  // DATA
    32'h51554954,  // QUIT
    32'h4E4F4F50,  // NOOP
    32'h4558504E,  // EXPN
    32'h52534554,  // RSET
    32'h48454C50,  // HELP
    32'h56524659   // VRFY
  };

  // One input transaction
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_item_t;

  // One result transaction
  typedef struct packed {
    logic       arg_valid;
    logic [8:0] arg_start;
    logic [9:0] arg_len;
    logic [7:0] arg_number;
    logic       line_done;
    logic       accepted;
    logic [3:0] command;
    logic [2:0] status;
    logic [8:0] arg_total;
  } result_t;

  // Match a packed verb against the table: {hit, code}
  function automatic logic [4:0] verb_lookup(input logic [31:0] verb);
    logic [4:0] r;
    r = '0;
    for (int i = NUM_VERBS - 1; i >= 0; i--) begin
      if (VERB_TABLE[i] == verb) begin
        r = {1'b1, 4'(i)};
      end
    end
    return r;
  endfunction

endpackage

/* design/smtpclp_in_stage.sv */
module smtpclp_in_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  smtpclp_pkg::in_item_t item_i,
  input  logic                  take_i,
  output logic                  valid_o,
  output smtpclp_pkg::in_item_t item_o
);
  import smtpclp_pkg::*;

  logic     valid_q;
  in_item_t item_q;

  // Hold the register while it is full and not consumed
  assign in_stall_o = valid_q && !take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* design/smtpclp_parse.sv */
module smtpclp_parse #(
  parameter int MaxLine = smtpclp_pkg::MAX_LINE_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  take_i,
  input  smtpclp_pkg::in_item_t item_i,
  output logic                  res_valid_o,
  output smtpclp_pkg::result_t  res_o
);
  import smtpclp_pkg::*;

  localparam int PosW = $clog2(MaxLine + 1);

  // Parser phases
  localparam logic [2:0] PH_VERB = 3'd0;
  localparam logic [2:0] PH_SEP  = 3'd1;
  localparam logic [2:0] PH_ARG  = 3'd2;
  localparam logic [2:0] PH_CR   = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;
  localparam logic [2:0] PH_FAIL = 3'd5;

  logic [2:0]      phase_q, phase_d;
  logic [31:0]     verb_q, verb_d;
  logic [2:0]      vlen_q, vlen_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] astart_q, astart_d;
  logic [8:0]      acnt_q, acnt_d;
  logic [3:0]      code_q, code_d;
  logic [2:0]      lstat_q, lstat_d;

  logic            delim, upper, lower, letter, space_col;
  logic [7:0]      ch, ch_up;
  logic [31:0]     vb;
  logic [2:0]      vl;
  logic [4:0]      hit;
  logic            emit, fail;
  logic [2:0]      fail_code;
  logic [PosW-1:0] emit_start, emit_len;
  result_t         res;

  // Phase that follows a closed word
  function automatic logic [2:0] after_word(input logic [7:0] c);
    logic [2:0] p;
    if (c == CH_SPACE || c == CH_COLON) begin
      p = PH_SEP;
    end else if (c == CH_CR) begin
      p = PH_CR;
    end else begin
      p = PH_DONE;
    end
    return p;
  endfunction

  assign ch        = item_i.data;
  assign space_col = (ch == CH_SPACE) || (ch == CH_COLON);
  assign delim     = space_col || (ch == CH_CR) || (ch == CH_LF);
  assign upper     = (ch >= 8'h41) && (ch <= 8'h5A);
  assign lower     = (ch >= 8'h61) && (ch <= 8'h7A);
  assign letter    = upper || lower;
  assign ch_up     = lower ? (ch - 8'h20) : ch;

  // Verb shift register as it stands after this byte
  always_comb begin
    vb = verb_q;
    vl = vlen_q;
    if (!delim) begin
      if (vlen_q < 3'd4) begin
        vb = {verb_q[23:0], ch_up};
      end
      if (vlen_q < 3'd5) begin
        vl = vlen_q + 3'd1;
      end
    end
  end

  assign hit = verb_lookup(vb);

  // Per-byte step
  always_comb begin
    phase_d    = phase_q;
    verb_d     = verb_q;
    vlen_d     = vlen_q;
    pos_d      = pos_q;
    astart_d   = astart_q;
    acnt_d     = acnt_q;
    code_d     = code_q;
    lstat_d    = lstat_q;
    emit       = 1'b0;
    emit_start = astart_q;
    emit_len   = '0;
    fail       = 1'b0;
    fail_code  = ST_OK;
    res        = '0;

    if (pos_q >= PosW'(MaxLine)) begin
      fail      = 1'b1;
      fail_code = ST_TOO_LONG;
    end else begin
      pos_d = pos_q + PosW'(1);
      case (phase_q)
        PH_VERB: begin
          if (!delim && !letter) begin
            fail      = 1'b1;
            fail_code = ST_BAD_VERB;
          end else begin
            verb_d = vb;
            vlen_d = vl;
            if (delim || item_i.last) begin
              if (vl != 3'd4 || !hit[4]) begin
                fail      = 1'b1;
                fail_code = ST_UNKNOWN;
              end else begin
                code_d  = hit[3:0];
                phase_d = after_word(ch);
              end
            end
          end
        end
        PH_SEP: begin
          if (ch == CH_CR) begin
            phase_d = PH_CR;
          end else if (ch == CH_LF) begin
            phase_d = PH_DONE;
          end else if (!space_col) begin
            astart_d = pos_q;
            if (item_i.last) begin
              emit       = 1'b1;
              emit_start = pos_q;
              emit_len   = PosW'(1);
              phase_d    = PH_DONE;
            end else begin
              phase_d = PH_ARG;
            end
          end
        end
        PH_ARG: begin
          if (delim || item_i.last) begin
            emit       = 1'b1;
            emit_start = astart_q;
            emit_len   = pos_q - astart_q + (delim ? PosW'(0) : PosW'(1));
            phase_d    = after_word(ch);
          end
        end
        PH_CR: begin
          if (ch == CH_LF) begin
            phase_d = PH_DONE;
          end else begin
            fail      = 1'b1;
            fail_code = ST_BARE_CR;
          end
        end
        default: begin
        end
      endcase
    end

    // First error of the line wins
    if (fail) begin
      phase_d = PH_FAIL;
      if (lstat_q == ST_OK) begin
        lstat_d = fail_code;
      end
    end

    if (emit) begin
      res.arg_valid  = 1'b1;
      res.arg_start  = 9'(emit_start);
      res.arg_len    = 10'(emit_len);
      res.arg_number = acnt_q[7:0];
      if (acnt_q < 9'd511) begin
        acnt_d = acnt_q + 9'd1;
      end
    end

    // Verdict, then start a fresh line
    if (item_i.last) begin
      res.line_done = 1'b1;
      res.accepted  = (lstat_d == ST_OK);
      res.command   = code_d;
      res.status    = lstat_d;
      res.arg_total = acnt_d;
      phase_d  = PH_VERB;
      verb_d   = '0;
      vlen_d   = '0;
      pos_d    = '0;
      astart_d = '0;
      acnt_d   = '0;
      code_d   = '0;
      lstat_d  = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_VERB;
      verb_q   <= '0;
      vlen_q   <= '0;
      pos_q    <= '0;
      astart_q <= '0;
      acnt_q   <= '0;
      code_q   <= '0;
      lstat_q  <= ST_OK;
    end else if (take_i) begin
      phase_q  <= phase_d;
      verb_q   <= verb_d;
      vlen_q   <= vlen_d;
      pos_q    <= pos_d;
      astart_q <= astart_d;
      acnt_q   <= acnt_d;
      code_q   <= code_d;
      lstat_q  <= lstat_d;
    end
  end

  assign res_o       = res;
  assign res_valid_o = res.arg_valid || res.line_done;

endmodule

/* design/smtpclp_out_stage.sv */
module smtpclp_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  smtpclp_pkg::result_t res_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output smtpclp_pkg::result_t res_o
);
  import smtpclp_pkg::*;

  logic    valid_q;
  result_t res_q;

  // Slot can take a new result when empty or being drained
  assign free_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

/* design/smtp_command_line_parser.sv */
// SMTP command line parser. Bytes of a command line enter one per transaction,
// with line_end_i set on the final byte; results leave on the output channel, one
// for each byte that closes an argument and/or ends the line (the verdict carries
// accepted, command, status and the argument count). A new byte is taken every
// clock cycle as long as results are drained. A byte's result passes through the
// input register, then the result register, before it reaches the output. The rate
// is set by the parse step, which updates the line state for every byte.
module smtp_command_line_parser #(
  parameter int MaxLine = smtpclp_pkg::MAX_LINE_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] byte_in_i,
  input  logic       line_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       arg_valid_o,
  output logic [8:0] arg_start_o,
  output logic [9:0] arg_len_o,
  output logic [7:0] arg_number_o,
  output logic       line_done_o,
  output logic       accepted_o,
  output logic [3:0] command_o,
  output logic [2:0] status_o,
  output logic [8:0] arg_total_o
);
  import smtpclp_pkg::*;

  in_item_t in_item, cur_item;
  logic     cur_valid, take, out_free, res_valid;
  result_t  res, res_out;

  assign in_item.data = byte_in_i;
  assign in_item.last = line_end_i;

  // Step the parser when a byte is held and the result slot is free
  assign take = cur_valid && out_free;

  smtpclp_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .take_i     (take),
    .valid_o    (cur_valid),
    .item_o     (cur_item)
  );

  smtpclp_parse #(
    .MaxLine (MaxLine)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .item_i      (cur_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  smtpclp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take && res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign arg_valid_o  = res_out.arg_valid;
  assign arg_start_o  = res_out.arg_start;
  assign arg_len_o    = res_out.arg_len;
  assign arg_number_o = res_out.arg_number;
  assign line_done_o  = res_out.line_done;
  assign accepted_o   = res_out.accepted;
  assign command_o    = res_out.command;
  assign status_o     = res_out.status;
  assign arg_total_o  = res_out.arg_total;

`ifndef SYNTHESIS
  // Input backs up only behind a full, stalled result slot
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  // No empty result transactions
  a_no_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (arg_valid_o || line_done_o))
    else $error("result carries neither argument nor verdict");

  // Verdict flag agrees with the status code
  a_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && line_done_o) |-> (accepted_o == (status_o == ST_OK)))
    else $error("accepted does not match status");

  // Argument fields are zero when no argument is reported
  a_arg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !arg_valid_o) |-> (arg_len_o == '0 && arg_start_o == '0))
    else $error("argument fields set without an argument");
`endif

endmodule

/* sim/smtp_line_checker.sv */
module smtp_line_checker #(
  parameter int MaxLine = smtpclp_pkg::MAX_LINE_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] byte_in_i,
  input  logic       line_end_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic       arg_valid_i,
  input  logic [8:0] arg_start_i,
  input  logic [9:0] arg_len_i,
  input  logic [7:0] arg_number_i,
  input  logic       line_done_i,
  input  logic       accepted_i,
  input  logic [3:0] command_i,
  input  logic [2:0] status_i,
  input  logic [8:0] arg_total_i,
  output int         errors_o,
  output int         pending_o
);
  import smtpclp_pkg::*;

  typedef enum logic [2:0] {P_VERB, P_SEP, P_ARG, P_CR, P_DONE, P_FAIL} parse_phase_e;

  // Line state of the parser copy
  parse_phase_e phase;
  logic [31:0]  verb_word;
  logic [2:0]   verb_len;
  int unsigned  line_pos;
  int unsigned  arg_open_start;
  logic [8:0]   arg_count;
  logic [3:0]   cmd_code;
  logic [2:0]   line_err;

  // Results predicted but not yet seen on the output channel
  result_t expected_results[$];
  int      mismatches = 0;
  int      queued = 0;

  assign errors_o  = mismatches;
  assign pending_o = queued;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic clear_line();
    phase          = P_VERB;
    verb_word      = '0;
    verb_len       = '0;
    line_pos       = 0;
    arg_open_start = 0;
    arg_count      = '0;
    cmd_code       = '0;
    line_err       = ST_OK;
  endtask

  // First error of the line sticks
  task automatic mark_fail(input logic [2:0] code);
    if (line_err == ST_OK) line_err = code;
    phase = P_FAIL;
  endtask

  task automatic emit_arg(input int unsigned start, input int unsigned len, inout result_t r);
    r.arg_valid  = 1'b1;
    r.arg_start  = start[8:0];
    r.arg_len    = len[9:0];
    r.arg_number = arg_count[7:0];
    if (arg_count != 9'd511) arg_count = arg_count + 9'd1;
  endtask

  // Where a closed word leaves the parser
  function automatic parse_phase_e next_phase(input logic [7:0] ch);
    if (ch == CH_SPACE || ch == CH_COLON) return P_SEP;
    if (ch == CH_CR) return P_CR;
    return P_DONE;
  endfunction

  // Parse one byte; hit tells whether it yields a result
  task automatic parse_byte(input logic [7:0] ch, input logic last,
                            output logic hit, output result_t r);
    logic        is_delim;
    logic        is_upper;
    logic        is_lower;
    logic        found;
    logic [3:0]  code;
    int unsigned pos;
    r        = '0;
    pos      = line_pos;
    is_delim = (ch == CH_SPACE || ch == CH_COLON || ch == CH_CR || ch == CH_LF);
    is_upper = (ch >= "A" && ch <= "Z");
    is_lower = (ch >= "a" && ch <= "z");
    if (pos >= MaxLine) begin
      mark_fail(ST_TOO_LONG);
    end else begin
      line_pos = pos + 1;
      case (phase)
        P_VERB: begin
          if (!is_delim && !is_upper && !is_lower) begin
            mark_fail(ST_BAD_VERB);
          end else begin
            if (!is_delim) begin
              if (verb_len < 3'd4) verb_word = {verb_word[23:0], is_lower ? ch - 8'd32 : ch};
              if (verb_len < 3'd5) verb_len = verb_len + 3'd1;
            end
            if (is_delim || last) begin
              found = 1'b0;
              code  = '0;
              if (verb_len == 3'd4) begin
                for (int i = 0; i < NUM_VERBS; i++) begin
                  if (!found && VERB_TABLE[i] == verb_word) begin
                    found = 1'b1;
                    code  = 4'(i);
                  end
                end
              end
              if (!found) begin
                mark_fail(ST_UNKNOWN);
              end else begin
                cmd_code = code;
                phase    = next_phase(ch);
              end
            end
          end
        end
        P_SEP: begin
          if (ch == CH_CR) begin
            phase = P_CR;
          end else if (ch == CH_LF) begin
            phase = P_DONE;
          end else if (ch != CH_SPACE && ch != CH_COLON) begin
            arg_open_start = pos;
            if (last) begin
              // argument opened on the final byte counts one byte
              emit_arg(pos, 1, r);
              phase = P_DONE;
            end else begin
              phase = P_ARG;
            end
          end
        end
        P_ARG: begin
          if (is_delim || last) begin
            emit_arg(arg_open_start, pos - arg_open_start + (is_delim ? 0 : 1), r);
            phase = next_phase(ch);
          end
        end
        P_CR: begin
          if (ch == CH_LF) phase = P_DONE;
          else mark_fail(ST_BARE_CR);
        end
        default: begin
        end
      endcase
    end
    // Verdict closes the line
    if (last) begin
      r.line_done = 1'b1;
      r.accepted  = (line_err == ST_OK);
      r.command   = cmd_code;
      r.status    = line_err;
      r.arg_total = arg_count;
      clear_line();
    end
    hit = r.arg_valid || r.line_done;
  endtask

  // Watch both channels: check outgoing results, then predict for the incoming byte
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t seen;
    result_t want;
    result_t r;
    logic    hit;
    if (!rst_ni) begin
      clear_line();
      expected_results.delete();
      queued = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        seen = {arg_valid_i, arg_start_i, arg_len_i, arg_number_i, line_done_i,
                accepted_i, command_i, status_i, arg_total_i};
        if (expected_results.size() == 0) begin
          report_mismatch("result with no transaction pending", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (seen.arg_valid !== want.arg_valid)
            report_mismatch("arg_valid", seen.arg_valid, want.arg_valid);
          if (seen.arg_start !== want.arg_start)
            report_mismatch("arg_start", seen.arg_start, want.arg_start);
          if (seen.arg_len !== want.arg_len)
            report_mismatch("arg_len", seen.arg_len, want.arg_len);
          if (seen.arg_number !== want.arg_number)
            report_mismatch("arg_number", seen.arg_number, want.arg_number);
          if (seen.line_done !== want.line_done)
            report_mismatch("line_done", seen.line_done, want.line_done);
          if (seen.accepted !== want.accepted)
            report_mismatch("accepted", seen.accepted, want.accepted);
          if (seen.command !== want.command)
            report_mismatch("command", seen.command, want.command);
          if (seen.status !== want.status)
            report_mismatch("status", seen.status, want.status);
          if (seen.arg_total !== want.arg_total)
            report_mismatch("arg_total", seen.arg_total, want.arg_total);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        parse_byte(byte_in_i, line_end_i, hit, r);
        if (hit) expected_results.push_back(r);
      end
      queued = expected_results.size();
    end
  end

endmodule

/* sim/tb_smtp_command_line_parser.sv */
module tb_smtp_command_line_parser;
  import smtpclp_pkg::*;

  localparam int RANDOM_BYTES   = 1300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 12;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] byte_in_i;
  logic       line_end_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       arg_valid_o;
  logic [8:0] arg_start_o;
  logic [9:0] arg_len_o;
  logic [7:0] arg_number_o;
  logic       line_done_o;
  logic       accepted_o;
  logic [3:0] command_o;
  logic [2:0] status_o;
  logic [8:0] arg_total_o;

  int         errors;
  int         pending;
  int         quiet_cycles = 0;
  logic       tx_no_gaps = 1'b0;
  logic       hold_off_req = 1'b0;
  logic [7:0] line_buf[$];

  smtp_command_line_parser #(
    .MaxLine(MAX_LINE_DEFAULT)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .byte_in_i   (byte_in_i),
    .line_end_i  (line_end_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .arg_valid_o (arg_valid_o),
    .arg_start_o (arg_start_o),
    .arg_len_o   (arg_len_o),
    .arg_number_o(arg_number_o),
    .line_done_o (line_done_o),
    .accepted_o  (accepted_o),
    .command_o   (command_o),
    .status_o    (status_o),
    .arg_total_o (arg_total_o)
  );

  smtp_line_checker #(
    .MaxLine(MAX_LINE_DEFAULT)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .byte_in_i   (byte_in_i),
    .line_end_i  (line_end_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .arg_valid_i (arg_valid_o),
    .arg_start_i (arg_start_o),
    .arg_len_i   (arg_len_o),
    .arg_number_i(arg_number_o),
    .line_done_i (line_done_o),
    .accepted_i  (accepted_o),
    .command_i   (command_o),
    .status_i    (status_o),
    .arg_total_i (arg_total_o),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: too long without any transaction on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("smtp_command_line_parser regression: fail");
      $finish;
    end
  end

  function automatic logic is_delim(input logic [7:0] b);
    return b == CH_SPACE || b == CH_COLON || b == CH_CR || b == CH_LF;
  endfunction

  // Any byte that does not split words
  function automatic logic [7:0] arg_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_delim(b));
    return b;
  endfunction

  // Neither letter nor delimiter: illegal inside a verb
  function automatic logic [7:0] odd_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (is_delim(b) || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z"));
    return b;
  endfunction

  function automatic logic [7:0] letter();
    logic [7:0] b;
    b = 8'($urandom_range(0, 25)) + 8'h41;
    if ($urandom_range(0, 1) == 1) b = b | 8'h20;
    return b;
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  // Known verb with each letter in random case
  task automatic add_verb();
    int         k;
    logic [7:0] c;
    k = $urandom_range(0, NUM_VERBS - 1);
    for (int j = 0; j < 4; j++) begin
      c = VERB_TABLE[k][31 - 8 * j -: 8];
      if ($urandom_range(0, 1) == 1) c = c | 8'h20;
      line_buf.push_back(c);
    end
  endtask

  task automatic add_seps(input int n);
    repeat (n) line_buf.push_back(($urandom_range(0, 1) == 1) ? CH_SPACE : CH_COLON);
  endtask

  task automatic add_word(input int n);
    repeat (n) line_buf.push_back(arg_byte());
  endtask

  // One input transaction; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_in_i  <= b;
    line_end_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) send_byte(line_buf[i], i == line_buf.size() - 1);
    line_buf.delete();
  endtask

  // Result sink: random stalls, bursts without stalls, one long hold-off
  initial begin : result_sink
    int n;
    int rx_run;
    out_stall_i = 1'b0;
    rx_run = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        if (rx_run > 0) begin
          rx_run--;
          n = 0;
        end else begin
          n = $urandom_range(0, 3);
          if ($urandom_range(0, 15) == 0) rx_run = 20;
        end
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(negedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    int lines;
    int random_bytes;
    int roll;
    int pick;
    int n;
    in_valid_i = 1'b0;
    byte_in_i  = 8'h00;
    line_end_i = 1'b0;
    rst_ni     = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed lines: lower-case verb with colon and one-byte final argument
    add_text("vrfy:a");
    send_line();
    // top byte value in the verb
    line_buf.push_back(8'hFF);
    send_line();
    // empty verb
    add_text(" ");
    send_line();
    // CR as final byte
    add_text("NOOP");
    line_buf.push_back(CH_CR);
    send_line();
    // CR followed by something other than LF
    add_text("MAIL");
    line_buf.push_back(CH_CR);
    add_text("x");
    send_line();
    // LF ends parsing, trailing byte ignored
    add_text("DATA");
    line_buf.push_back(CH_LF);
    add_text("Z");
    send_line();

    // Random lines
    lines = 0;
    random_bytes = 0;
    while (random_bytes < RANDOM_BYTES) begin
      if (lines == 6) begin
        // exactly MAX_LINE bytes, packed with one-byte arguments
        add_text("HELO");
        repeat ((MAX_LINE_DEFAULT - 4) / 2) begin
          add_seps(1);
          line_buf.push_back(arg_byte());
        end
      end else if (lines == 25) begin
        // very long argument, then the line runs past MAX_LINE
        add_text("MAIL ");
        add_word(MAX_LINE_DEFAULT - 6);
        add_text(" ");
        add_word(2);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
          // well-formed command
          add_verb();
          n = $urandom_range(0, 4);
          repeat (n) begin
            add_seps($urandom_range(1, 3));
            add_word(($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6));
          end
          pick = $urandom_range(0, 99);
          if (pick < 15) begin
            add_seps($urandom_range(1, 2));
          end else if (pick < 40) begin
            line_buf.push_back(CH_CR);
            line_buf.push_back(CH_LF);
          end else if (pick < 55) begin
            line_buf.push_back(CH_LF);
            repeat ($urandom_range(0, 3)) line_buf.push_back(8'($urandom_range(0, 255)));
          end else if (pick < 65) begin
            line_buf.push_back(CH_CR);
          end
        end else if (roll < 72) begin
          // raw noise
          repeat ($urandom_range(1, 10)) line_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
          // broken commands
          pick = $urandom_range(0, 4);
          case (pick)
            0: begin
              n = $urandom_range(1, 6);
              if (n >= 4) n++;
              repeat (n) line_buf.push_back(letter());
              if ($urandom_range(0, 1) == 1) begin
                add_seps(1);
                add_word(2);
              end
            end
            1: begin
              repeat (4) line_buf.push_back(letter());
              if ($urandom_range(0, 1) == 1) begin
                add_seps(1);
                add_word(3);
              end
            end
            2: begin
              add_verb();
              line_buf[$urandom_range(0, 3)] = odd_byte();
              add_seps(1);
              add_word(3);
            end
            3: begin
              add_verb();
              add_seps(1);
              add_word($urandom_range(1, 4));
              line_buf.push_back(CH_CR);
              line_buf.push_back(8'($urandom_range(0, 255)));
              add_word(2);
            end
            default: begin
              n = $urandom_range(0, 3);
              line_buf.push_back(n == 0 ? CH_SPACE : n == 1 ? CH_COLON : n == 2 ? CH_CR : CH_LF);
              add_verb();
            end
          endcase
        end
      end
      random_bytes += line_buf.size();
      if (lines == 12) hold_off_req = 1'b1;
      tx_no_gaps = ($urandom_range(0, 3) == 0);
      send_line();
      lines++;
    end
    in_valid_i <= 1'b0;

    // Drain and settle
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("smtp_command_line_parser regression: pass");
    end else begin
      $display("smtp_command_line_parser regression: fail");
    end
    $finish;
  end

endmodule
